>>> rtl/core/bffe_pkg.sv
// ----------------------------------------------------------------------------
// bffe_pkg
// Request and status codes shared by the bitmap engine core and its checker.
// ----------------------------------------------------------------------------
package bffe_pkg;

	localparam int WORD_BITS = 32;

	localparam logic [2:0] OP_ZERO   = 3'd0;
	localparam logic [2:0] OP_FILL   = 3'd1;
	localparam logic [2:0] OP_TEST   = 3'd2;
	localparam logic [2:0] OP_SET    = 3'd3;
	localparam logic [2:0] OP_CLR    = 3'd4;
	localparam logic [2:0] OP_FIND1  = 3'd5;
	localparam logic [2:0] OP_FIND0  = 3'd6;
	localparam logic [2:0] OP_COUNT  = 3'd7;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_RANGE     = 2'd2;

endpackage

>>> rtl/core/bitmap_find_first_engine_core.sv
// ----------------------------------------------------------------------------
// bitmap_find_first_engine_core
// Bitmap store with bit test/set/clear, find-first set/clear and popcount.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears on
// status, bit_value, found_index and set_count for one cycle with done high, and
// must be taken then. The map lives in a 32-bit word memory with one write and
// one read port, one word read per cycle. An out-of-range indexed request answers
// without going busy; test, set and clear touch only the word holding the bit;
// zero, fill and count walk the N = ceil(size/32) words in use; a find walks the
// words from the start word up to the hit or the map end. After reset a clearing
// pass over all ceil(MAP_BITS/32) words runs with busy high; map_size writes are
// taken at any time through cfg_we/cfg_wdata but must only be done while idle.
// ----------------------------------------------------------------------------
module bitmap_find_first_engine_core #(
	parameter int MAP_BITS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [2:0]  req_type,
	input  logic [9:0]  bit_index,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	output logic        done,
	output logic [1:0]  status,
	output logic        bit_value,
	output logic [9:0]  found_index,
	output logic [10:0] set_count
);

	localparam int WORDS = (MAP_BITS + 31) / 32;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int CW    = $clog2(WORDS + 1);

	localparam logic [1:0] S_CLR  = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_RUN  = 2'd2;

	function automatic logic [5:0] popcnt32(input logic [31:0] x);
		logic [31:0] a, b, c, d, e;
		a = x - ((x >> 1) & 32'h5555_5555);
		b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
		c = (b + (b >> 4)) & 32'h0F0F_0F0F;
		d = c + (c >> 8);
		e = d + (d >> 16);
		return e[5:0];
	endfunction

	// isolate lowest one, then encode its position
	function automatic logic [4:0] low_pos(input logic [31:0] x);
		logic [31:0] iso;
		logic [4:0]  p;
		iso  = x & (~x + 32'd1);
		p[0] = |(iso & 32'hAAAA_AAAA);
		p[1] = |(iso & 32'hCCCC_CCCC);
		p[2] = |(iso & 32'hF0F0_F0F0);
		p[3] = |(iso & 32'hFF00_FF00);
		p[4] = |(iso & 32'hFFFF_0000);
		return p;
	endfunction

	logic [31:0]   mem [WORDS];
	logic [31:0]   rd_data_q;

	logic [1:0]    state_q;
	logic [CW-1:0] word_q;
	logic          valid_s1;
	logic [AW-1:0] addr_s1;
	logic [10:0]   map_size_q;

	logic [10:0]   eff_q;
	logic [2:0]    op_q;
	logic [9:0]    idx_q;
	logic [AW-1:0] start_q;
	logic [CW-1:0] end_q;
	logic [10:0]   acc_q;

	logic          done_q;
	logic [1:0]    status_q;
	logic          bit_value_q;
	logic [9:0]    found_q;
	logic [10:0]   count_q;

	// request decode
	logic [10:0]   eff;
	logic [11:0]   nwords_sum;
	logic [CW-1:0] nwords;
	logic [AW-1:0] idx_word;
	logic          accept;
	logic          indexed;
	logic          bulk;
	logic          oor;

	// word processing
	logic          issue;
	logic          finish;
	logic          last;
	logic [31:0]   use_m;
	logic [31:0]   start_m;
	logic [31:0]   bit_m;
	logic [31:0]   cand;
	logic [10:0]   acc_next;
	logic [16:0]   hit_global;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;

	logic [1:0]    res_status;
	logic          res_bit;
	logic [9:0]    res_found;
	logic [10:0]   res_count;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		eff = ({6'd0, map_size_q} > 17'(MAP_BITS)) ? 11'(MAP_BITS) : map_size_q;
	end

	assign nwords_sum = {1'b0, eff} + 12'd31;
	assign nwords     = CW'(nwords_sum >> 5);
	assign idx_word   = AW'({7'd0, bit_index} >> 5);
	assign accept     = start && !busy;
	assign oor        = ({1'b0, bit_index} >= eff);

	always_comb begin
		indexed = req_type inside {[bffe_pkg::OP_TEST:bffe_pkg::OP_FIND0]};
		bulk    = req_type inside {bffe_pkg::OP_ZERO, bffe_pkg::OP_FILL, bffe_pkg::OP_COUNT};
	end

	// masks for the word now out of the memory
	always_comb begin
		if (17'(addr_s1) < 17'(eff_q[10:5])) begin
			use_m = '1;
		end else if (17'(addr_s1) == 17'(eff_q[10:5])) begin
			use_m = (32'd1 << eff_q[4:0]) - 32'd1;
		end else begin
			use_m = '0;
		end
		start_m = (addr_s1 == start_q) ? ~((32'd1 << idx_q[4:0]) - 32'd1) : '1;
		bit_m   = 32'd1 << idx_q[4:0];
	end

	assign last       = ((CW'(addr_s1) + CW'(1)) == end_q);
	assign cand       = ((op_q == bffe_pkg::OP_FIND1) ? rd_data_q : ~rd_data_q) & use_m & start_m;
	assign acc_next   = acc_q + 11'(popcnt32(rd_data_q & use_m));
	assign hit_global = (17'(addr_s1) << 5) | 17'(low_pos(cand));

	always_comb begin
		finish     = 1'b0;
		res_status = bffe_pkg::ST_OK;
		res_bit    = 1'b0;
		res_found  = '0;
		res_count  = '0;
		we         = 1'b0;
		waddr      = addr_s1;
		wdata      = rd_data_q;
		if (state_q == S_CLR) begin
			we    = 1'b1;
			waddr = word_q[AW-1:0];
			wdata = '0;
		end else if (state_q == S_IDLE) begin
			if (accept && indexed && oor) begin
				finish     = 1'b1;
				res_status = bffe_pkg::ST_RANGE;
			end
		end else if (valid_s1) begin
			case (op_q)
				bffe_pkg::OP_TEST: begin
					finish  = 1'b1;
					res_bit = rd_data_q[idx_q[4:0]];
				end
				bffe_pkg::OP_SET: begin
					finish = 1'b1;
					we     = 1'b1;
					wdata  = rd_data_q | bit_m;
				end
				bffe_pkg::OP_CLR: begin
					finish = 1'b1;
					we     = 1'b1;
					wdata  = rd_data_q & ~bit_m;
				end
				bffe_pkg::OP_ZERO, bffe_pkg::OP_FILL: begin
					finish = last;
					we     = 1'b1;
					wdata  = (rd_data_q & ~use_m) |
						((op_q == bffe_pkg::OP_FILL) ? use_m : 32'd0);
				end
				bffe_pkg::OP_COUNT: begin
					finish    = last;
					res_count = acc_next;
				end
				bffe_pkg::OP_FIND1, bffe_pkg::OP_FIND0: begin
					if (|cand) begin
						finish    = 1'b1;
						res_found = hit_global[9:0];
					end else if (last) begin
						finish     = 1'b1;
						res_status = bffe_pkg::ST_NOT_FOUND;
					end
				end
				default: begin
					finish = 1'b1;
				end
			endcase
		end else if (word_q >= end_q) begin
			// zero-size map: nothing to walk
			finish = 1'b1;
		end
	end

	assign issue = (state_q == S_RUN) && (word_q < end_q) && !finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			word_q     <= '0;
			valid_s1   <= 1'b0;
			done_q     <= 1'b0;
			map_size_q <= 11'd1024;
		end else begin
			done_q   <= finish;
			valid_s1 <= issue;
			if (cfg_we) begin
				map_size_q <= cfg_wdata;
			end
			case (state_q)
				S_CLR: begin
					word_q <= word_q + CW'(1);
					if (word_q == CW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && !(indexed && oor)) begin
						state_q <= S_RUN;
						word_q  <= bulk ? '0 : CW'(idx_word);
					end
				end
				S_RUN: begin
					if (issue) begin
						word_q <= word_q + CW'(1);
					end
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eff_q   <= eff;
			op_q    <= req_type;
			idx_q   <= bit_index;
			start_q <= idx_word;
			acc_q   <= '0;
			if (bulk) begin
				end_q <= nwords;
			end else if (req_type == bffe_pkg::OP_FIND1 || req_type == bffe_pkg::OP_FIND0) begin
				end_q <= nwords;
			end else begin
				end_q <= CW'(idx_word) + CW'(1);
			end
		end else if (state_q == S_RUN && valid_s1) begin
			acc_q <= acc_next;
		end
		if (issue) begin
			addr_s1 <= word_q[AW-1:0];
		end
		if (finish) begin
			status_q    <= res_status;
			bit_value_q <= res_bit;
			found_q     <= res_found;
			count_q     <= res_count;
		end
	end

	// word memory with one write and one read port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rd_data_q <= mem[word_q[AW-1:0]];
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign bit_value   = bit_value_q;
	assign found_index = found_q;
	assign set_count   = count_q;

endmodule

>>> rtl/core/bffe_checker.sv
// ----------------------------------------------------------------------------
// bffe_checker
// Port-level checks for the bitmap engine core, bound to the core module.
// ----------------------------------------------------------------------------
module bffe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [2:0]  req_type,
	input logic        done,
	input logic [1:0]  status,
	input logic        bit_value,
	input logic [9:0]  found_index,
	input logic [10:0] set_count
);

	// whole-map requests always walk memory, so busy follows
	a_bulk_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (req_type == bffe_pkg::OP_ZERO || req_type == bffe_pkg::OP_FILL ||
			req_type == bffe_pkg::OP_COUNT)) |=> busy)
		else $error("whole-map request did not go busy");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == bffe_pkg::ST_OK || status == bffe_pkg::ST_NOT_FOUND ||
			status == bffe_pkg::ST_RANGE))
		else $error("illegal status word");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != bffe_pkg::ST_OK) |->
			(!bit_value && found_index == 10'd0 && set_count == 11'd0))
		else $error("failed word carries nonzero fields");

	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		(done && bit_value) |-> (found_index == 10'd0 && set_count == 11'd0))
		else $error("test word carries search or count fields");

endmodule

bind bitmap_find_first_engine_core bffe_checker u_bffe_checker (.*);
